### sv/stdp_pkg.sv
// shared constants and types for the sieve / trial division prime tester
`timescale 1ns / 1ps
package stdp_pkg;
  localparam int SieveSize = 4096;
  localparam int PrimeSlots = 1024;
  localparam int CandBits = 25;
  localparam int LimitW = 13;
  localparam int MarkAw = $clog2(SieveSize + 1);
  localparam int SlotAw = $clog2(PrimeSlots);
  localparam int CountW = $clog2(PrimeSlots + 1);
  localparam int PrimeW = $clog2(SieveSize + 1);
  localparam logic [0:0] ReqBuild = 1'b0;
  localparam logic [0:0] ReqTest = 1'b1;
  localparam logic [0:0] StatusOk = 1'b0;
  localparam logic [0:0] StatusNotBuilt = 1'b1;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [CandBits-1:0] dividend;
    logic [PrimeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero_rem;
  } div_rsp_t;
endpackage

### sv/stdp_divider.sv
// bit-serial remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module stdp_divider (
  input  logic clk,
  input  logic rst,
  input  stdp_pkg::div_req_t req,
  output stdp_pkg::div_rsp_t rsp
);
  localparam int CntW = $clog2(stdp_pkg::CandBits + 1);

  logic [stdp_pkg::CandBits-1:0] num;
  logic [stdp_pkg::PrimeW-1:0] den;
  logic [stdp_pkg::PrimeW:0] rem;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [stdp_pkg::PrimeW+1:0] shifted;
  logic [stdp_pkg::PrimeW+1:0] diff;

  always_comb begin
    shifted = {rem, num[stdp_pkg::CandBits-1]};
    diff = shifted - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      rsp.zero_rem <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
      cnt <= CntW'(stdp_pkg::CandBits);
    end else if (busy) begin
      num <= {num[stdp_pkg::CandBits-2:0], 1'b0};
      if (!diff[stdp_pkg::PrimeW+1]) rem <= diff[stdp_pkg::PrimeW:0];
      else rem <= shifted[stdp_pkg::PrimeW:0];
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        rsp.done <= 1'b1;
        rsp.zero_rem <= diff[stdp_pkg::PrimeW+1] ? (shifted == '0) : (diff == '0);
      end
    end
  end
endmodule

### sv/sieve_trial_division_prime_test_core.sv
// top level: sieve builder and trial division tester around two memories
// build: a clear pass over entries 2..L, then a scan of every entry (read, then check),
//   with a marking pass over the multiples of each unmarked entry p <= L/2
// test: per base prime tried, a table read, a divider start and a wait for the remainder
// one request at a time; next request accepted once result is taken
// the trial divider is a bit-serial unit, used once for each base prime tried
// reset: synchronous; clears count, built flag and limit (4096), memories not cleared
`timescale 1ns / 1ps
module sieve_trial_division_prime_test_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic req_type,
  input  logic [24:0] candidate,
  output logic out_valid,
  input  logic out_stall,
  output logic status,
  output logic is_prime,
  output logic [10:0] base_count
);
  localparam int MW = stdp_pkg::MarkAw;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SCAN_RD, S_SCAN_CHK, S_MARK, S_T_RD, S_T_WAIT, S_T_DIV, S_DONE
  } state_t;

  state_t state;
  logic [stdp_pkg::LimitW-1:0] base_limit;
  logic [MW-1:0] lim, idx, step, mk;
  logic [stdp_pkg::CountW-1:0] count;
  logic built;
  logic [stdp_pkg::CandBits-1:0] cand;
  logic [stdp_pkg::CountW-1:0] k;

  logic marks [0:stdp_pkg::SieveSize];
  logic mark_rd;
  logic [stdp_pkg::PrimeW-1:0] table_mem [0:stdp_pkg::PrimeSlots-1];
  logic [stdp_pkg::PrimeW-1:0] tab_rd;

  logic mark_we, mark_wv;
  logic [MW-1:0] mark_wa, mark_ra;
  logic tab_we;

  stdp_pkg::div_req_t dreq;
  stdp_pkg::div_rsp_t drsp;

  stdp_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // a waiting result blocks the next request
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    mark_we = 1'b0;
    mark_wv = 1'b0;
    mark_wa = idx;
    mark_ra = idx;
    if (state == S_CLR) mark_we = 1'b1;
    if (state == S_MARK) begin
      mark_we = 1'b1;
      mark_wv = 1'b1;
      mark_wa = mk;
    end
    tab_we = (state == S_SCAN_CHK) && !mark_rd &&
             (count < stdp_pkg::CountW'(stdp_pkg::PrimeSlots));
    dreq.start = (state == S_T_WAIT);
    dreq.dividend = cand;
    dreq.divisor = tab_rd;
  end

  always_ff @(posedge clk) begin
    if (mark_we) marks[mark_wa] <= mark_wv;
    mark_rd <= marks[mark_ra];
    if (tab_we) table_mem[count[stdp_pkg::SlotAw-1:0]] <= idx[stdp_pkg::PrimeW-1:0];
    tab_rd <= table_mem[k[stdp_pkg::SlotAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base_limit <= 13'd4096;
      count <= '0;
      built <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) base_limit <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && (!out_valid || !out_stall)) begin
            cand <= candidate;
            k <= '0;
            if (req_type == stdp_pkg::ReqBuild) begin
              lim <= (base_limit > 13'(stdp_pkg::SieveSize)) ?
                     MW'(stdp_pkg::SieveSize) : MW'(base_limit);
              idx <= MW'(2);
              count <= '0;
              state <= S_CLR;
            end else if (!built) begin
              status <= stdp_pkg::StatusNotBuilt;
              is_prime <= 1'b0;
              base_count <= '0;
              state <= S_DONE;
            end else begin
              state <= S_T_RD;
            end
          end
        end
        S_CLR: begin
          if (idx >= lim) begin
            idx <= MW'(2);
            state <= S_SCAN_RD;
          end else idx <= idx + 1'b1;
          if (lim < MW'(2)) begin
            idx <= MW'(2);
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx > lim || lim < MW'(2)) begin
            built <= 1'b1;
            status <= stdp_pkg::StatusOk;
            is_prime <= 1'b0;
            base_count <= 11'(count);
            state <= S_DONE;
          end else state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!mark_rd) begin
            if (tab_we) count <= count + 1'b1;
            step <= idx;
            mk <= idx + idx;
            if ({1'b0, idx} + {1'b0, idx} <= {1'b0, lim}) state <= S_MARK;
            else begin
              idx <= idx + 1'b1;
              state <= S_SCAN_RD;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_MARK: begin
          mk <= mk + step;
          if ({1'b0, mk} + {1'b0, step} > {1'b0, lim}) begin
            idx <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_T_RD: begin
          if (k >= count) begin
            status <= stdp_pkg::StatusOk;
            is_prime <= 1'b1;
            base_count <= 11'(count);
            state <= S_DONE;
          end else state <= S_T_WAIT;
        end
        S_T_WAIT: state <= S_T_DIV;
        S_T_DIV: begin
          if (drsp.done) begin
            if (drsp.zero_rem) begin
              status <= stdp_pkg::StatusOk;
              is_prime <= 1'b0;
              base_count <= 11'(count);
              state <= S_DONE;
            end else begin
              k <= k + 1'b1;
              state <= S_T_RD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
